// ===== sv/crc_framed_stream_deframer_top_macros.svh =====
// ----------------------------------------------------------------------------
// crc framed stream deframer assertion macros
// concurrent assertion wrappers shared by the deframer rtl
// ----------------------------------------------------------------------------
`ifndef CRC_FRAMED_STREAM_DEFRAMER_TOP_MACROS_SVH
`define CRC_FRAMED_STREAM_DEFRAMER_TOP_MACROS_SVH

// check sampled on clk, masked while reset is held
`define CFSD_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check sampled on clk, also active during reset
`define CFSD_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/cfsd_pkg.sv =====
// ----------------------------------------------------------------------------
// cfsd_pkg
// types, codes and crc helper for the length prefixed frame deframer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cfsd_pkg;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_MAGIC_FIRST  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAGIC_SECOND = 1'd1;

  localparam logic [7:0] MAGIC_FIRST_RST  = 8'hA5;
  localparam logic [7:0] MAGIC_SECOND_RST = 8'h5A;

  // crc-16/ccitt-false
  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;

  // record kinds
  typedef logic [1:0] kind_t;
  localparam kind_t KIND_PAYLOAD = 2'd0;
  localparam kind_t KIND_ACCEPT  = 2'd1;
  localparam kind_t KIND_REJECT  = 2'd2;

  // parser phases
  typedef enum logic [7:0] {
    PH_HUNT0   = 8'b0000_0001,
    PH_HUNT1   = 8'b0000_0010,
    PH_TYPE    = 8'b0000_0100,
    PH_LEN_LO  = 8'b0000_1000,
    PH_LEN_HI  = 8'b0001_0000,
    PH_PAYLOAD = 8'b0010_0000,
    PH_CRC_LO  = 8'b0100_0000,
    PH_CRC_HI  = 8'b1000_0000
  } phase_t;

  // one byte of crc update, msb first
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== sv/cfsd_if.sv =====
// ----------------------------------------------------------------------------
// cfsd stream interfaces
// byte input channel and record output channel, valid/ready handshake
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

// received byte channel
interface cfsd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// deframed record channel
interface cfsd_out_if;
  import cfsd_pkg::*;
  logic        valid;
  logic        ready;
  kind_t       record_kind;
  logic [7:0]  payload_byte;
  logic [15:0] payload_index;
  logic [7:0]  frame_type;
  logic [15:0] frame_length;
  logic [15:0] received_crc;
  logic [15:0] computed_crc;
  logic        frame_end;

  modport source (
    output valid, output record_kind, output payload_byte, output payload_index,
    output frame_type, output frame_length, output received_crc, output computed_crc,
    output frame_end, input ready
  );
  modport sink (
    input valid, input record_kind, input payload_byte, input payload_index,
    input frame_type, input frame_length, input received_crc, input computed_crc,
    input frame_end, output ready
  );
endinterface

`default_nettype wire

// ===== sv/crc_framed_stream_deframer_top.sv =====
// ----------------------------------------------------------------------------
// crc_framed_stream_deframer_top
// sync hunt, header parse, payload pass-through and crc-16 check per byte
// ----------------------------------------------------------------------------
//  channel      dir   handshake        contents
//  in_stream    in    valid/ready      rx_byte
//  out_stream   out   valid/ready      one record per payload byte or frame end
//  cfg_*        in    write enable     magic_first (0), magic_second (1)
//
//  one byte per cycle while the output keeps taking records; a byte sits
//  in the input register, the parser and byte-wide crc update run
//  combinationally from it into the record register
//  a stalled output holds the record and the input register; ready drops only
//  while the record register is full and not taken
//  synchronous active-low reset returns to the sync hunt, no clearing pass
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module crc_framed_stream_deframer_top (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  cfsd_in_if.sink                             in_stream,
  cfsd_out_if.source                          out_stream,
  input  wire logic                           cfg_we,
  input  wire logic [cfsd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [7:0]                     cfg_wdata
);
  import cfsd_pkg::*;

  // configuration
  logic [7:0] magic_first_r, magic_second_r;

  // input register
  logic       in_v_r;
  logic [7:0] in_byte_r;

  // parser state
  phase_t      phase_r, phase_nxt;
  logic [7:0]  type_r, type_nxt;
  logic [15:0] len_r, len_nxt;
  logic [15:0] left_r, left_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [7:0]  crc_lo_r, crc_lo_nxt;

  // result register
  logic        out_v_r, out_v_nxt;
  kind_t       kind_r, kind_nxt;
  logic [7:0]  pbyte_r, pbyte_nxt;
  logic [15:0] pidx_r, pidx_nxt;
  logic [7:0]  ftype_r, ftype_nxt;
  logic [15:0] flen_r, flen_nxt;
  logic [15:0] rcrc_r, rcrc_nxt;
  logic [15:0] ccrc_r, ccrc_nxt;
  logic        fend_r, fend_nxt;
  logic        res_v;

  logic        advance;
  logic        in_xfer;
  logic [15:0] crc_upd;
  logic [15:0] rx_crc;
  logic [15:0] left_dec;

  // pipeline moves when a byte is held and the record slot is free or being drained
  assign advance  = in_v_r && (!out_v_r || out_stream.ready);
  assign in_stream.ready = !in_v_r || advance;
  assign in_xfer  = in_stream.valid && in_stream.ready;

  assign crc_upd  = crc_byte(crc_r, in_byte_r);
  assign rx_crc   = {in_byte_r, crc_lo_r};
  assign left_dec = left_r - 16'd1;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      magic_first_r  <= MAGIC_FIRST_RST;
      magic_second_r <= MAGIC_SECOND_RST;
    end else if (cfg_we) begin
      if (cfg_index == REG_MAGIC_FIRST) begin
        magic_first_r <= cfg_wdata;
      end
      if (cfg_index == REG_MAGIC_SECOND) begin
        magic_second_r <= cfg_wdata;
      end
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_xfer) begin
      in_v_r <= 1'b1;
    end else if (advance) begin
      in_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      in_byte_r <= in_stream.rx_byte;
    end
  end

  // parser and record build
  always_comb begin
    phase_nxt  = phase_r;
    type_nxt   = type_r;
    len_nxt    = len_r;
    left_nxt   = left_r;
    crc_nxt    = crc_r;
    crc_lo_nxt = crc_lo_r;
    res_v      = 1'b0;
    kind_nxt   = KIND_PAYLOAD;
    pbyte_nxt  = 8'h00;
    pidx_nxt   = 16'h0000;
    ftype_nxt  = type_r;
    flen_nxt   = len_r;
    rcrc_nxt   = 16'h0000;
    ccrc_nxt   = 16'h0000;
    fend_nxt   = 1'b0;
    unique case (phase_r)
      PH_HUNT0: begin
        if (in_byte_r == magic_first_r) begin
          phase_nxt = PH_HUNT1;
        end
      end
      PH_HUNT1: begin
        // second magic wins over a repeated first magic
        priority if (in_byte_r == magic_second_r) begin
          phase_nxt = PH_TYPE;
          crc_nxt   = CRC_INIT;
        end else if (in_byte_r != magic_first_r) begin
          phase_nxt = PH_HUNT0;
        end else begin
          // repeated first magic keeps waiting
          phase_nxt = PH_HUNT1;
        end
      end
      PH_TYPE: begin
        type_nxt  = in_byte_r;
        crc_nxt   = crc_upd;
        phase_nxt = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        len_nxt   = {8'h00, in_byte_r};
        crc_nxt   = crc_upd;
        phase_nxt = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        len_nxt   = {in_byte_r, len_r[7:0]};
        left_nxt  = {in_byte_r, len_r[7:0]};
        crc_nxt   = crc_upd;
        // empty payload skips straight to the footer
        phase_nxt = ({in_byte_r, len_r[7:0]} == 16'h0000) ? PH_CRC_LO : PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        crc_nxt   = crc_upd;
        res_v     = 1'b1;
        kind_nxt  = KIND_PAYLOAD;
        pbyte_nxt = in_byte_r;
        pidx_nxt  = len_r - left_r;
        left_nxt  = left_dec;
        if (left_dec == 16'h0000) begin
          phase_nxt = PH_CRC_LO;
        end
      end
      PH_CRC_LO: begin
        crc_lo_nxt = in_byte_r;
        phase_nxt  = PH_CRC_HI;
      end
      PH_CRC_HI: begin
        res_v     = 1'b1;
        kind_nxt  = (rx_crc == crc_r) ? KIND_ACCEPT : KIND_REJECT;
        rcrc_nxt  = rx_crc;
        ccrc_nxt  = crc_r;
        fend_nxt  = 1'b1;
        phase_nxt = PH_HUNT0;
      end
      default: begin
        phase_nxt = PH_HUNT0;
      end
    endcase
  end

  // parser state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT0;
    end else if (advance) begin
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r <= CRC_INIT;
    end else if (advance) begin
      crc_r <= crc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      type_r   <= type_nxt;
      len_r    <= len_nxt;
      left_r   <= left_nxt;
      crc_lo_r <= crc_lo_nxt;
    end
  end

  // record register valid
  always_comb begin
    out_v_nxt = out_v_r && !out_stream.ready;
    if (advance) begin
      out_v_nxt = res_v;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= out_v_nxt;
    end
  end

  // record payload
  always_ff @(posedge clk) begin
    if (advance && res_v) begin
      kind_r  <= kind_nxt;
      pbyte_r <= pbyte_nxt;
      pidx_r  <= pidx_nxt;
      ftype_r <= ftype_nxt;
      flen_r  <= flen_nxt;
      rcrc_r  <= rcrc_nxt;
      ccrc_r  <= ccrc_nxt;
      fend_r  <= fend_nxt;
    end
  end

  assign out_stream.valid         = out_v_r;
  assign out_stream.record_kind   = kind_r;
  assign out_stream.payload_byte  = pbyte_r;
  assign out_stream.payload_index = pidx_r;
  assign out_stream.frame_type    = ftype_r;
  assign out_stream.frame_length  = flen_r;
  assign out_stream.received_crc  = rcrc_r;
  assign out_stream.computed_crc  = ccrc_r;
  assign out_stream.frame_end     = fend_r;

`include "crc_framed_stream_deframer_top_macros.svh"

  // end records carry an accept or reject verdict
  `CFSD_ASSERT_RST(a_end_kind, out_v_r && fend_r |-> (kind_r == KIND_ACCEPT || kind_r == KIND_REJECT), "end record without verdict")

  // accept only when both crc values agree
  `CFSD_ASSERT_RST(a_accept_match, out_v_r && kind_r == KIND_ACCEPT |-> rcrc_r == ccrc_r, "frame accepted with crc mismatch")

  // payload index stays inside the announced length
  `CFSD_ASSERT_RST(a_index_range, out_v_r && !fend_r |-> pidx_r < flen_r, "payload index past frame length")

  // no record right after reset
  `CFSD_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_v_r && !in_v_r, "pipeline not empty after reset")

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench for crc_framed_stream_deframer_top
// streams synced frames, noise and broken sync sequences into the deframer
// under random valid and ready gaps, predicts every payload and end record
// in step with each byte transfer, and checks the records field by field
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import cfsd_pkg::*;

  // one record as the deframer emits it
  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data;
    logic [15:0] index;
    logic [7:0]  ftype;
    logic [15:0] flen;
    logic [15:0] rx_crc;
    logic [15:0] calc_crc;
    logic        last;
  } deframe_rec_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [7:0] cfg_wdata;

  cfsd_in_if  in_ch ();
  cfsd_out_if out_ch ();

  crc_framed_stream_deframer_top DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_stream  (in_ch.sink),
    .out_stream (out_ch.source),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always #1 clk = ~clk;

  // sync bytes as currently programmed
  logic [7:0] sync_first;
  logic [7:0] sync_second;

  // parser state mirror
  phase_t      parse_state = PH_HUNT0;
  logic [7:0]  cur_type    = 8'h00;
  logic [15:0] cur_len     = 16'h0000;
  logic [15:0] remaining   = 16'h0000;
  logic [15:0] crc_acc     = CRC_INIT;
  logic [7:0]  footer_lo   = 8'h00;

  logic [7:0]   rx_stream[$];
  deframe_rec_t predicted_records[$];
  int unsigned  bytes_queued = 0;
  int unsigned  bytes_taken  = 0;
  int unsigned  error_count  = 0;

  bit in_fire  = 1'b0;
  bit rec_fire = 1'b0;
  bit in_burst = 1'b0;
  bit out_burst = 1'b0;
  int in_gap   = 0;
  int out_wait = 0;

  // crc-16/ccitt-false, one input bit per pass
  function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] r;
    logic fb;
    int k;
    r = crc;
    for (k = 7; k >= 0; k--) begin
      fb = r[15] ^ b[k];
      r = {r[14:0], 1'b0};
      if (fb) begin
        r = r ^ CRC_POLY;
      end
    end
    return r;
  endfunction

  task automatic report(input string msg);
    error_count++;
    if (error_count <= 100) begin
      $display("mismatch @%0t: %s", $realtime, msg);
    end
  endtask

  // advance the parser mirror by one transferred byte
  task automatic deframe_byte(input logic [7:0] b);
    deframe_rec_t rec;
    logic [15:0] footer;
    rec = '0;
    case (parse_state)
      PH_HUNT0: begin
        if (b == sync_first) parse_state = PH_HUNT1;
      end
      PH_HUNT1: begin
        // second magic wins when both magics are equal
        if (b == sync_second) begin
          parse_state = PH_TYPE;
          crc_acc = CRC_INIT;
        end else if (b != sync_first) begin
          parse_state = PH_HUNT0;
        end
      end
      PH_TYPE: begin
        cur_type = b;
        crc_acc = crc16_step(crc_acc, b);
        parse_state = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        cur_len = {8'h00, b};
        crc_acc = crc16_step(crc_acc, b);
        parse_state = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        cur_len[15:8] = b;
        crc_acc = crc16_step(crc_acc, b);
        remaining = cur_len;
        // empty frame skips straight to the footer
        if (cur_len == 16'h0000) begin
          parse_state = PH_CRC_LO;
        end else begin
          parse_state = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        crc_acc = crc16_step(crc_acc, b);
        rec.kind  = KIND_PAYLOAD;
        rec.data  = b;
        rec.index = cur_len - remaining;
        rec.ftype = cur_type;
        rec.flen  = cur_len;
        predicted_records.insert(predicted_records.size(), rec);
        remaining = remaining - 16'd1;
        if (remaining == 16'h0000) parse_state = PH_CRC_LO;
      end
      PH_CRC_LO: begin
        footer_lo = b;
        parse_state = PH_CRC_HI;
      end
      default: begin
        footer = {b, footer_lo};
        rec.kind     = (footer == crc_acc) ? KIND_ACCEPT : KIND_REJECT;
        rec.ftype    = cur_type;
        rec.flen     = cur_len;
        rec.rx_crc   = footer;
        rec.calc_crc = crc_acc;
        rec.last     = 1'b1;
        predicted_records.insert(predicted_records.size(), rec);
        parse_state = PH_HUNT0;
      end
    endcase
  endtask

  task automatic check_record();
    deframe_rec_t want;
    if (predicted_records.size() == 0) begin
      report($sformatf("record kind %0d with nothing expected", out_ch.record_kind));
      return;
    end
    want = predicted_records.pop_front();
    if (out_ch.record_kind !== want.kind)
      report($sformatf("record_kind %0d, want %0d", out_ch.record_kind, want.kind));
    if (out_ch.payload_byte !== want.data)
      report($sformatf("payload_byte %h, want %h", out_ch.payload_byte, want.data));
    if (out_ch.payload_index !== want.index)
      report($sformatf("payload_index %0d, want %0d", out_ch.payload_index, want.index));
    if (out_ch.frame_type !== want.ftype)
      report($sformatf("frame_type %h, want %h", out_ch.frame_type, want.ftype));
    if (out_ch.frame_length !== want.flen)
      report($sformatf("frame_length %0d, want %0d", out_ch.frame_length, want.flen));
    if (out_ch.received_crc !== want.rx_crc)
      report($sformatf("received_crc %h, want %h", out_ch.received_crc, want.rx_crc));
    if (out_ch.computed_crc !== want.calc_crc)
      report($sformatf("computed_crc %h, want %h", out_ch.computed_crc, want.calc_crc));
    if (out_ch.frame_end !== want.last)
      report($sformatf("frame_end %b, want %b", out_ch.frame_end, want.last));
  endtask

  // sample both channels at the rising edge
  always @(posedge clk) begin
    in_fire  <= rst_n && in_ch.valid && in_ch.ready;
    rec_fire <= rst_n && out_ch.valid && out_ch.ready;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      deframe_byte(in_ch.rx_byte);
      bytes_taken++;
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      check_record();
    end
  end

  // byte driver, random gap before each transfer
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_gap <= 0;
    end else if (!in_ch.valid || in_fire) begin
      if (in_gap > 0) begin
        in_ch.valid <= 1'b0;
        in_gap <= in_gap - 1;
      end else if (rx_stream.size() != 0) begin
        in_ch.valid <= 1'b1;
        in_ch.rx_byte <= rx_stream.pop_front();
        if ($urandom_range(0, 39) == 0) in_burst = !in_burst;
        in_gap <= in_burst ? 0 : $urandom_range(0, 10);
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // record sink, random stall after each transfer
  always @(negedge clk) begin : ready_drive
    int w;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      out_wait <= 0;
    end else begin
      if (rec_fire) begin
        if ($urandom_range(0, 39) == 0) out_burst = !out_burst;
        w = out_burst ? 0 : $urandom_range(0, 10);
      end else begin
        w = out_wait;
      end
      if (w > 0) begin
        out_ch.ready <= 1'b0;
        out_wait <= w - 1;
      end else begin
        out_ch.ready <= 1'b1;
        out_wait <= 0;
      end
    end
  end

  function automatic void push_byte(input logic [7:0] b);
    rx_stream.insert(rx_stream.size(), b);
    bytes_queued++;
  endfunction

  // full frame with the current sync bytes; fill < 0 gives random payload
  task automatic queue_frame(input logic [7:0] ftype, input logic [15:0] len,
                             input int fill, input bit bad_crc);
    logic [15:0] crc;
    logic [7:0] b;
    int unsigned k;
    push_byte(sync_first);
    push_byte(sync_second);
    push_byte(ftype);
    push_byte(len[7:0]);
    push_byte(len[15:8]);
    crc = crc16_step(CRC_INIT, ftype);
    crc = crc16_step(crc, len[7:0]);
    crc = crc16_step(crc, len[15:8]);
    for (k = 0; k < len; k++) begin
      b = (fill < 0) ? 8'($urandom) : fill[7:0];
      crc = crc16_step(crc, b);
      push_byte(b);
    end
    if (bad_crc) crc = crc ^ 16'($urandom_range(1, 65535));
    push_byte(crc[7:0]);
    push_byte(crc[15:8]);
  endtask

  // mostly good frames, plus noise, broken sync and repeated first magic
  task automatic gen_traffic(input int unsigned budget);
    int unsigned start;
    int unsigned sel;
    int unsigned n;
    logic [7:0] b;
    start = bytes_queued;
    while (bytes_queued - start < budget) begin
      sel = $urandom_range(0, 99);
      if (sel < 72) begin
        n = ($urandom_range(0, 19) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
        queue_frame(8'($urandom), 16'(n), -1, $urandom_range(0, 6) == 0);
      end else if (sel < 82) begin
        // noise that never starts a sync
        repeat ($urandom_range(1, 5)) begin
          do b = 8'($urandom); while (b == sync_first);
          push_byte(b);
        end
      end else if (sel < 92) begin
        // first magic followed by a stray byte
        push_byte(sync_first);
        do b = 8'($urandom); while (b == sync_first || b == sync_second);
        push_byte(b);
      end else begin
        if (sync_first != sync_second) begin
          repeat ($urandom_range(1, 3)) push_byte(sync_first);
        end
        queue_frame(8'($urandom), 16'($urandom_range(0, 8)), -1, 1'b0);
      end
    end
  endtask

  task automatic wait_idle();
    while (bytes_taken != bytes_queued || predicted_records.size() != 0) @(negedge clk);
    // bytes without a record may still sit in the pipeline
    repeat (4) @(negedge clk);
  endtask

  task automatic write_magic(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_MAGIC_FIRST) begin
      sync_first = value;
    end else begin
      sync_second = value;
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = 8'h00;
    in_ch.valid = 1'b0;
    in_ch.rx_byte = 8'h00;
    out_ch.ready = 1'b0;
    sync_first = MAGIC_FIRST_RST;
    sync_second = MAGIC_SECOND_RST;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    // directed: extremes, empty frame, repeated first magic, bad crc, broken sync
    push_byte(8'h00);
    push_byte(8'hFF);
    queue_frame(8'hFF, 16'd0, -1, 1'b0);
    push_byte(sync_first);
    queue_frame(8'h00, 16'd1, 8'h00, 1'b0);
    queue_frame(8'h80, 16'd2, 8'hFF, 1'b1);
    push_byte(sync_first);
    push_byte(8'h33);
    gen_traffic(440);
    wait_idle();

    // extreme sync values
    write_magic(REG_MAGIC_FIRST, 8'h00);
    write_magic(REG_MAGIC_SECOND, 8'hFF);
    gen_traffic(220);
    wait_idle();

    // equal magics: the repeated byte is taken as the second magic
    write_magic(REG_MAGIC_FIRST, 8'h3C);
    write_magic(REG_MAGIC_SECOND, 8'h3C);
    queue_frame(8'h3C, 16'd3, -1, 1'b0);
    push_byte(8'h3C);
    push_byte(8'h11);
    gen_traffic(220);
    wait_idle();

    // reversed extremes, one long frame for the upper length byte
    write_magic(REG_MAGIC_FIRST, 8'hFF);
    write_magic(REG_MAGIC_SECOND, 8'h00);
    queue_frame(8'h5A, 16'h0123, -1, 1'b0);
    gen_traffic(150);
    wait_idle();

    if (error_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("testbench: done, errors");
    $finish;
  end

endmodule
